// ===== rtl/pcbb_pkg.sv =====
package pcbb_pkg;

  localparam int DIM_W = 13;
  localparam int POS_W = 12;
  localparam int PAD_W = 8;
  localparam int CHAN_W = 8;
  localparam int CFG_IDX_W = 2;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [PAD_W-1:0] pad_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam dim_t MAX_DIMENSION = DIM_W'(4096);
  localparam chan_t WHITE_LEVEL = CHAN_W'(8'hff);

  localparam dim_t WIDTH_RESET = DIM_W'(640);
  localparam dim_t HEIGHT_RESET = DIM_W'(480);
  localparam pad_t PAD_RESET = PAD_W'(4);

  localparam cfg_idx_t REG_FRAME_WIDTH = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam cfg_idx_t REG_PAD_AMOUNT = CFG_IDX_W'(2);

  // Frame bounds handed from the accumulator to the box stage
  typedef struct packed {
    logic found;
    pos_t min_column;
    pos_t max_column;
    pos_t min_row;
    pos_t max_row;
    dim_t width;
    dim_t height;
    pad_t pad;
  } frame_bounds_t;

  function automatic dim_t effective_dim(input dim_t v);
    dim_t r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_DIMENSION) begin
      r = MAX_DIMENSION;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/pcbb_span.sv =====
module pcbb_span import pcbb_pkg::*; (
  input  logic found,
  input  pos_t least,
  input  pos_t greatest,
  input  dim_t dim,
  input  pad_t pad,
  output pos_t lo,
  output pos_t hi
);

  dim_t start;
  dim_t left_full;
  dim_t right_full;
  pos_t last;
  pos_t left;
  pos_t base;

  always_comb begin
    last = POS_W'(dim - DIM_W'(1));
    start = found ? {1'b0, least} : dim;
    left_full = (start > DIM_W'(pad)) ? start - DIM_W'(pad) : '0;
    left = (left_full > {1'b0, last}) ? last : left_full[POS_W-1:0];
    base = found ? greatest : left;
    if (base < left) begin
      base = left;
    end
    right_full = {1'b0, base} + DIM_W'(pad);
    hi = (right_full > {1'b0, last}) ? last : right_full[POS_W-1:0];
    lo = left;
  end

endmodule

// ===== rtl/padded_content_bounding_box.sv =====
// Padded content bounding box.
// Pixels of one frame enter on the in_valid/in_ready channel in raster order,
// one transaction per pixel. A pixel is content when any channel is not 255.
// After the last pixel of a frame one transaction leaves on out_valid/out_ready
// carrying the content box widened by the pad and clamped to the frame; right
// and bottom are inclusive. A frame with no content reports content_found low.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes width
// (0), height (1) and pad (2); cfg_ready is always high. Write it between
// frames or while the block is idle; a write mid-frame takes effect at once.
// Throughput: one pixel per cycle while in_ready is high. The box of a frame
// passes one bounds register, then one box register, after its last pixel.
// If the receiver stalls, the finished box waits in the output register and a
// second one in the bounds register; while both are full, in_ready is low and
// every pixel waits until the output transaction is taken.
// Reset (rst, synchronous) restores width 640, height 480, pad 4, starts a new
// frame and drops any pending result.
module padded_content_bounding_box import pcbb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  dim_t     cfg_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  chan_t    red,
  input  chan_t    green,
  input  chan_t    blue,
  output logic     out_valid,
  input  logic     out_ready,
  output pos_t     box_left,
  output pos_t     box_right,
  output pos_t     box_top,
  output pos_t     box_bottom,
  output logic     content_found
);

  dim_t frame_width;
  dim_t frame_height;
  pad_t pad_amount;

  pos_t column_count, column_count_next;
  pos_t row_count, row_count_next;
  pos_t min_column, min_column_next;
  pos_t max_column, max_column_next;
  pos_t min_row, min_row_next;
  pos_t max_row, max_row_next;
  logic any_content, any_content_next;

  frame_bounds_t bounds, bounds_next;
  logic bounds_valid;

  dim_t w_eff;
  dim_t h_eff;
  logic in_fire;
  logic out_free;
  logic is_content;
  logic end_of_frame;
  pos_t left_w, right_w, top_w, bottom_w;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || out_ready;
  assign in_ready = !bounds_valid || out_free;
  assign in_fire = in_valid && in_ready;
  assign w_eff = effective_dim(frame_width);
  assign h_eff = effective_dim(frame_height);
  assign is_content = (red != WHITE_LEVEL) || (green != WHITE_LEVEL) ||
                      (blue != WHITE_LEVEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      pad_amount <= PAD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_PAD_AMOUNT:   pad_amount <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    min_column_next = min_column;
    max_column_next = max_column;
    min_row_next = min_row;
    max_row_next = max_row;
    any_content_next = any_content;
    column_count_next = column_count;
    row_count_next = row_count;
    end_of_frame = 1'b0;
    if (is_content) begin
      if (column_count < min_column) min_column_next = column_count;
      if (column_count > max_column) max_column_next = column_count;
      if (row_count < min_row) min_row_next = row_count;
      if (row_count > max_row) max_row_next = row_count;
      any_content_next = 1'b1;
    end
    if (({1'b0, column_count} + DIM_W'(1)) >= w_eff) begin
      column_count_next = '0;
      if (({1'b0, row_count} + DIM_W'(1)) >= h_eff) begin
        end_of_frame = 1'b1;
      end else begin
        row_count_next = row_count + POS_W'(1);
      end
    end else begin
      column_count_next = column_count + POS_W'(1);
    end

    bounds_next.found = any_content_next;
    bounds_next.min_column = min_column_next;
    bounds_next.max_column = max_column_next;
    bounds_next.min_row = min_row_next;
    bounds_next.max_row = max_row_next;
    bounds_next.width = w_eff;
    bounds_next.height = h_eff;
    bounds_next.pad = pad_amount;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      min_column <= '1;
      max_column <= '0;
      min_row <= '1;
      max_row <= '0;
      any_content <= 1'b0;
    end else if (in_fire) begin
      if (end_of_frame) begin
        column_count <= '0;
        row_count <= '0;
        min_column <= '1;
        max_column <= '0;
        min_row <= '1;
        max_row <= '0;
        any_content <= 1'b0;
      end else begin
        column_count <= column_count_next;
        row_count <= row_count_next;
        min_column <= min_column_next;
        max_column <= max_column_next;
        min_row <= min_row_next;
        max_row <= max_row_next;
        any_content <= any_content_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds_valid <= 1'b0;
    end else if (in_fire && end_of_frame) begin
      bounds_valid <= 1'b1;
    end else if (bounds_valid && out_free) begin
      bounds_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && end_of_frame) begin
      bounds <= bounds_next;
    end
  end

  pcbb_span u_span_x (
    .found    (bounds.found),
    .least    (bounds.min_column),
    .greatest (bounds.max_column),
    .dim      (bounds.width),
    .pad      (bounds.pad),
    .lo       (left_w),
    .hi       (right_w)
  );

  pcbb_span u_span_y (
    .found    (bounds.found),
    .least    (bounds.min_row),
    .greatest (bounds.max_row),
    .dim      (bounds.height),
    .pad      (bounds.pad),
    .lo       (top_w),
    .hi       (bottom_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (bounds_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bounds_valid && out_free) begin
      box_left <= left_w;
      box_right <= right_w;
      box_top <= top_w;
      box_bottom <= bottom_w;
      content_found <= bounds.found;
    end
  end

endmodule

// ===== rtl/pcbb_checker.sv =====
module pcbb_checker import pcbb_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_ready,
  input pos_t     box_left,
  input pos_t     box_right,
  input pos_t     box_top,
  input pos_t     box_bottom,
  input logic     content_found
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_cols_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> box_left <= box_right)
    else $error("box_left beyond box_right");

  a_rows_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> box_top <= box_bottom)
    else $error("box_top beyond box_bottom");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(box_left) &&
      $stable(box_right) && $stable(box_top) && $stable(box_bottom) &&
      $stable(content_found))
    else $error("result dropped or changed while stalled");

endmodule

bind padded_content_bounding_box pcbb_checker u_pcbb_checker (.*);

// ===== dv/padded_content_bounding_box_checker.sv =====
`timescale 1ns / 100ps

module padded_content_bounding_box_checker import pcbb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  dim_t     cfg_data,
  input  logic     in_valid,
  input  logic     in_ready,
  input  chan_t    red,
  input  chan_t    green,
  input  chan_t    blue,
  input  logic     out_valid,
  input  logic     out_ready,
  input  pos_t     box_left,
  input  pos_t     box_right,
  input  pos_t     box_top,
  input  pos_t     box_bottom,
  input  logic     content_found,
  output int       fail_count,
  output int       outstanding,
  output int       boxes_checked,
  output int       blank_boxes
);

  typedef struct packed {
    pos_t left;
    pos_t right;
    pos_t top;
    pos_t bottom;
    logic found;
  } crop_box_t;

  dim_t width_reg;
  dim_t height_reg;
  pad_t pad_reg;
  pos_t col_pos;
  pos_t row_pos;
  pos_t lo_col;
  pos_t hi_col;
  pos_t lo_row;
  pos_t hi_row;
  logic seen_ink;
  crop_box_t crop_q[$];
  crop_box_t got;
  crop_box_t want;

  function automatic int clip_extent(input dim_t v);
    if (v == '0) return 1;
    if (v > MAX_DIMENSION) return int'(MAX_DIMENSION);
    return int'(v);
  endfunction

  function automatic void restart_frame();
    col_pos = '0;
    row_pos = '0;
    lo_col = '1;
    hi_col = '0;
    lo_row = '1;
    hi_row = '0;
    seen_ink = 1'b0;
  endfunction

  // Padded span along one axis, clamped to [0, extent - 1]
  function automatic void pad_axis(input logic found, input pos_t least, input pos_t greatest,
                                   input int extent, input pad_t pad,
                                   output pos_t lo, output pos_t hi);
    int last;
    int start;
    int lo_i;
    int base;
    int hi_i;
    last = extent - 1;
    start = found ? int'(least) : extent;
    lo_i = (start > int'(pad)) ? start - int'(pad) : 0;
    if (lo_i > last) lo_i = last;
    base = found ? int'(greatest) : lo_i;
    if (base < lo_i) base = lo_i;
    hi_i = base + int'(pad);
    if (hi_i > last) hi_i = last;
    lo = pos_t'(lo_i);
    hi = pos_t'(hi_i);
  endfunction

  function automatic void track_pixel(input chan_t r, input chan_t g, input chan_t b);
    int w;
    int h;
    pos_t x_lo;
    pos_t x_hi;
    pos_t y_lo;
    pos_t y_hi;
    w = clip_extent(width_reg);
    h = clip_extent(height_reg);
    if (r != WHITE_LEVEL || g != WHITE_LEVEL || b != WHITE_LEVEL) begin
      if (col_pos < lo_col) lo_col = col_pos;
      if (col_pos > hi_col) hi_col = col_pos;
      if (row_pos < lo_row) lo_row = row_pos;
      if (row_pos > hi_row) hi_row = row_pos;
      seen_ink = 1'b1;
    end
    if (int'(col_pos) + 1 >= w) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= h) begin
        pad_axis(seen_ink, lo_col, hi_col, w, pad_reg, x_lo, x_hi);
        pad_axis(seen_ink, lo_row, hi_row, h, pad_reg, y_lo, y_hi);
        crop_q.push_back('{x_lo, x_hi, y_lo, y_hi, seen_ink});
        restart_frame();
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%t: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      pad_reg = PAD_RESET;
      restart_frame();
      crop_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH: width_reg = cfg_data;
          REG_FRAME_HEIGHT: height_reg = cfg_data;
          REG_PAD_AMOUNT: pad_reg = cfg_data[PAD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) track_pixel(red, green, blue);
      if (out_valid && out_ready) begin
        got = '{box_left, box_right, box_top, box_bottom, content_found};
        if (crop_q.size() == 0) begin
          note_failure($sformatf("unexpected box: l=%0d r=%0d t=%0d b=%0d found=%0b",
                                 got.left, got.right, got.top, got.bottom, got.found));
        end else begin
          want = crop_q.pop_front();
          boxes_checked++;
          if (!want.found) blank_boxes++;
          if (got.left !== want.left || got.right !== want.right || got.top !== want.top ||
              got.bottom !== want.bottom || got.found !== want.found) begin
            note_failure($sformatf(
              "box mismatch: exp l=%0d r=%0d t=%0d b=%0d found=%0b, got l=%0d r=%0d t=%0d b=%0d found=%0b",
              want.left, want.right, want.top, want.bottom, want.found,
              got.left, got.right, got.top, got.bottom, got.found));
          end
        end
      end
    end
    outstanding <= crop_q.size();
  end

endmodule

// ===== dv/padded_content_bounding_box_test.sv =====
`timescale 1ns / 100ps

module padded_content_bounding_box_test import pcbb_pkg::*;;

  localparam cfg_idx_t REG_SPARE = CFG_IDX_W'(3);

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = REG_FRAME_WIDTH;
  dim_t     cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  chan_t    red = WHITE_LEVEL;
  chan_t    green = WHITE_LEVEL;
  chan_t    blue = WHITE_LEVEL;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pos_t     box_left;
  pos_t     box_right;
  pos_t     box_top;
  pos_t     box_bottom;
  logic     content_found;
  int       fail_count;
  int       outstanding;
  int       boxes_checked;
  int       blank_boxes;

  bit   quiet = 1'b0;
  dim_t cur_w = WIDTH_RESET;
  dim_t cur_h = HEIGHT_RESET;
  int   total_pixels = 0;
  int   random_pixels = 0;

  padded_content_bounding_box dut (.*);
  padded_content_bounding_box_checker box_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int span(input dim_t v);
    return (v == '0) ? 1 : (v > MAX_DIMENSION) ? int'(MAX_DIMENSION) : int'(v);
  endfunction

  function automatic void pick_pixel(input int ink_pct, output chan_t r, output chan_t g,
                                     output chan_t b);
    r = WHITE_LEVEL;
    g = WHITE_LEVEL;
    b = WHITE_LEVEL;
    if ($urandom_range(99, 0) < ink_pct) begin
      case ($urandom_range(3, 0))
        0: r = chan_t'($urandom);
        1: g = chan_t'($urandom);
        2: b = chan_t'($urandom);
        default: begin
          r = chan_t'($urandom);
          g = chan_t'($urandom);
          b = chan_t'($urandom);
        end
      endcase
    end
  endfunction

  task automatic push_pixel(input chan_t r, input chan_t g, input chan_t b);
    int gap;
    gap = quiet ? 0 : $urandom_range(14, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    total_pixels++;
  endtask

  // Lowers in_valid, waits for every pending box, then lets the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input dim_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input dim_t w, input dim_t h, input pad_t p);
    settle();
    cur_w = w;
    cur_h = h;
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_PAD_AMOUNT, {5'($urandom), p});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input int ink_pct);
    chan_t r;
    chan_t g;
    chan_t b;
    repeat (span(cur_w) * span(cur_h)) begin
      pick_pixel(ink_pct, r, g, b);
      push_pixel(r, g, b);
    end
  endtask

  initial begin : drain
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(14, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    dim_t w;
    dim_t h;
    pad_t p;
    int ink;
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // start a frame at reset geometry, then shrink it mid-frame
    for (n = 0; n < 5; n++) push_pixel((n == 2) ? 8'h00 : WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);
    settle();
    cur_w = 3;
    cur_h = 2;
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 2);
    write_reg(REG_SPARE, dim_t'($urandom));
    cfg_valid <= 1'b0;
    for (n = 0; n < 4; n++) push_pixel(WHITE_LEVEL, WHITE_LEVEL, (n == 3) ? 8'h00 : WHITE_LEVEL);

    configure(1, 1, 0);
    push_pixel(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);
    push_pixel(8'h00, 8'h00, 8'h00);

    // zero sizes behave as one
    configure(0, 0, 8'hff);
    push_pixel(WHITE_LEVEL, WHITE_LEVEL, 8'hfe);
    push_pixel(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);

    configure(2, 2, 0);
    push_pixel(8'h00, WHITE_LEVEL, WHITE_LEVEL);
    push_pixel(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);
    push_pixel(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);
    push_pixel(WHITE_LEVEL, 8'h7f, WHITE_LEVEL);
    for (n = 0; n < 4; n++) push_pixel(WHITE_LEVEL, (n == 3) ? 8'h80 : WHITE_LEVEL, WHITE_LEVEL);

    configure(3, 3, 1);
    send_frame(0);
    configure(4, 3, 2);
    send_frame(30);

    // oversized and maximum sizes, each frame closed by a mid-frame shrink
    configure(8191, 2, 8'h80);
    for (n = 0; n < 6; n++) push_pixel((n == 4) ? 8'h10 : WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);
    configure(5, 2, 8'h80);
    for (n = 0; n < 6; n++) push_pixel(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);
    configure(1, 8191, 8'h03);
    for (n = 0; n < 5; n++) push_pixel(WHITE_LEVEL, (n == 3) ? 8'h00 : WHITE_LEVEL, WHITE_LEVEL);
    configure(1, 3, 8'h03);
    push_pixel(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);
    configure(4096, 1, 8'hff);
    for (n = 0; n < 3; n++) push_pixel(WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL);
    configure(3, 1, 8'hff);
    push_pixel(WHITE_LEVEL, WHITE_LEVEL, 8'h00);

    while (random_pixels < 1190) begin
      quiet = ($urandom_range(3, 0) == 0);
      case ($urandom_range(9, 0))
        0: w = 0;
        1: w = dim_t'($urandom_range(40, 9));
        default: w = dim_t'($urandom_range(8, 1));
      endcase
      case ($urandom_range(9, 0))
        0: h = 0;
        1: h = dim_t'($urandom_range(24, 9));
        default: h = dim_t'($urandom_range(8, 1));
      endcase
      p = ($urandom_range(3, 0) == 0) ? pad_t'($urandom) : pad_t'($urandom_range(6, 0));
      configure(w, h, p);
      repeat ($urandom_range(6, 1)) begin
        if (random_pixels < 1190) begin
          case ($urandom_range(4, 0))
            0: ink = 0;
            1: ink = 3;
            2: ink = 20;
            3: ink = 60;
            default: ink = 100;
          endcase
          send_frame(ink);
          random_pixels += span(cur_w) * span(cur_h);
        end
      end
    end

    settle();
    $display("Sent %0d pixel transactions (%0d in random frames); checked %0d boxes, %0d blank.",
             total_pixels, random_pixels, boxes_checked, blank_boxes);
    $display("Covered zero, maximum and oversized frame sizes, pads 0..255 and mid-frame resizes.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("padded_content_bounding_box test passed");
    end else begin
      $display("padded_content_bounding_box test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("padded_content_bounding_box test failed");
    $finish;
  end

endmodule
